@@ src/cbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the sequencer control store for the bank mapper.
// No dependencies; imported by cbm_rem and the top level.
package cbm_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int STEP_W      = 4;
   localparam int REM_W       = 8;

   // CPU register decode after masking
   localparam logic [15:0] ADDR_MASK       = 16'hE001;
   localparam logic [15:0] ADDR_SELECT     = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
   localparam logic [15:0] ADDR_RELOAD     = 16'hC000;
   localparam logic [15:0] ADDR_RELOAD_ARM = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;

   localparam logic [7:0] SEL_MASK     = 8'h0F;
   localparam logic [7:0] PRG_MASK     = 8'h3F;
   localparam logic [7:0] PAT_EVEN_MSK = 8'hFE;
   localparam logic [7:0] PAT_ODD_BIT  = 8'h01;
   localparam logic [7:0] FIXED_OFFSET = 8'hFE;

   localparam logic [3:0] SEL_LAST_PAT = 4'd5;
   localparam logic [3:0] SEL_PRG0     = 4'd8;
   localparam logic [3:0] SEL_PRG1     = 4'd9;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_PROGRAM = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTICAL  = 2'd2;

   localparam logic [7:0] PRG_COUNT_RESET = 8'd2;
   localparam logic [7:0] CHR_COUNT_RESET = 8'd0;
   localparam logic       VERTICAL_RESET  = 1'b0;

   localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;

   typedef enum logic [2:0] {
      SRC_PRG, SRC_FIXED, SRC_PAT_EVEN, SRC_PAT_ODD, SRC_PAT
   } src_type;

   typedef enum logic [1:0] {
      MOD_NONE, MOD_PRG, MOD_CHR
   } mod_type;

   typedef struct packed {
      src_type    src;
      logic [2:0] reg_idx;
      mod_type    modsel;
      logic [1:0] kind;
      logic [2:0] slot;
      logic       end_if_ram;   // stop here when pattern memory is RAM
      logic       last;
   } ucode_type;

   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] dividend;
      logic [REM_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [REM_W-1:0] remainder;
   } rem_rsp_type;

   // Slot map program: one control word per emitted record
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         4'd0:  w = '{SRC_PRG,      3'd0, MOD_PRG,  KIND_PROGRAM, 3'd0, 1'b0, 1'b0};
         4'd1:  w = '{SRC_PRG,      3'd1, MOD_PRG,  KIND_PROGRAM, 3'd1, 1'b0, 1'b0};
         4'd2:  w = '{SRC_FIXED,    3'd0, MOD_NONE, KIND_PROGRAM, 3'd2, 1'b0, 1'b0};
         4'd3:  w = '{SRC_FIXED,    3'd1, MOD_NONE, KIND_PROGRAM, 3'd3, 1'b1, 1'b0};
         4'd4:  w = '{SRC_PAT_EVEN, 3'd0, MOD_CHR,  KIND_PATTERN, 3'd0, 1'b0, 1'b0};
         4'd5:  w = '{SRC_PAT_ODD,  3'd0, MOD_CHR,  KIND_PATTERN, 3'd1, 1'b0, 1'b0};
         4'd6:  w = '{SRC_PAT_EVEN, 3'd1, MOD_CHR,  KIND_PATTERN, 3'd2, 1'b0, 1'b0};
         4'd7:  w = '{SRC_PAT_ODD,  3'd1, MOD_CHR,  KIND_PATTERN, 3'd3, 1'b0, 1'b0};
         4'd8:  w = '{SRC_PAT,      3'd2, MOD_CHR,  KIND_PATTERN, 3'd4, 1'b0, 1'b0};
         4'd9:  w = '{SRC_PAT,      3'd3, MOD_CHR,  KIND_PATTERN, 3'd5, 1'b0, 1'b0};
         4'd10: w = '{SRC_PAT,      3'd4, MOD_CHR,  KIND_PATTERN, 3'd6, 1'b0, 1'b0};
         4'd11: w = '{SRC_PAT,      3'd5, MOD_CHR,  KIND_PATTERN, 3'd7, 1'b0, 1'b1};
         default: w = '{SRC_PRG,    3'd0, MOD_NONE, KIND_STATUS,  3'd0, 1'b0, 1'b1};
      endcase
      return w;
   endfunction

endpackage

@@ src/cartridge_bank_mapper_with_scanline_irq_top.sv @@
`timescale 1ns / 1ps
// Cartridge bank mapper with scanline IRQ counter: register file, control
// store sequencer and output register. Depends on cbm_pkg and cbm_rem.
//
// Register writes, scanline ticks and writes that do not touch bank data are
// taken one per cycle as long as the result beat is taken; each gives one
// status beat. A bank-data write plays the slot map program from the control
// store: four program records then, unless the pattern bank count is zero,
// eight pattern records. Every record that needs a modulo runs through the
// shared bit-serial remainder unit: a fetch step, 8 bit steps in the unit and
// an issue step; a fixed program slot, or a program slot with a zero program
// bank count, has only the fetch and issue steps. No new beat is taken while
// the map is being played out, and output stalls hold the sequencer in its
// issue step.
module cartridge_bank_mapper_with_scanline_irq_top (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: cpu_address[15:0], write_data[23:16], rendering_on[24], zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cbm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,  // func
   // rsp_tdata: slot_index[2:0], bank_number[10:3], mirror_horizontal[11],
   //            irq_line[12], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cbm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // record_kind
   output logic                             rsp_tlast,  // last_record
   input  logic                             csr_we,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata
);
   import cbm_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DIV, S_PUT} state_type;

   // configuration
   logic [7:0] prg_count_ff, prg_count_in;
   logic [7:0] chr_count_ff, chr_count_in;

   // mapper registers
   logic [3:0] sel_ff, sel_in;
   logic [7:0] pat_ff [6];
   logic [7:0] pat_in [6];
   logic [5:0] prg_ff [2];
   logic [5:0] prg_in [2];
   logic       mir_ff, mir_in;
   logic       irqen_ff, irqen_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] rld_ff, rld_in;
   logic       rldp_ff, rldp_in;
   logic       irqp_ff, irqp_in;

   // sequencer and output register
   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [7:0]        res_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [2:0]        rsp_slot_ff;
   logic [7:0]        rsp_bank_ff;
   logic              rsp_mir_ff;
   logic              rsp_irq_ff;
   logic              rsp_last_ff;

   logic        out_free;
   logic        req_fire;
   logic        bank_wr;
   logic [15:0] reg_addr;
   logic [7:0]  wdata;
   logic [7:0]  cnt_next;
   ucode_type   uw;
   logic [7:0]  operand;
   logic        mod_needed;
   logic        map_load;
   logic        map_last;
   logic        rsp_load;
   rem_req_type rem_req;
   rem_rsp_type rem_rsp;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign reg_addr   = req_tdata[15:0] & ADDR_MASK;
   assign wdata      = req_tdata[23:16];
   assign cnt_next   = (cnt_ff == 8'd0 || rldp_ff) ? rld_ff : cnt_ff - 8'd1;

   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      sel_in       = sel_ff;
      pat_in       = pat_ff;
      prg_in       = prg_ff;
      mir_in       = mir_ff;
      irqen_in     = irqen_ff;
      cnt_in       = cnt_ff;
      rld_in       = rld_ff;
      rldp_in      = rldp_ff;
      irqp_in      = irqp_ff;
      bank_wr      = 1'b0;
      if (req_fire) begin
         if (req_tuser == FUNC_WRITE) begin
            case (reg_addr)
               ADDR_SELECT: sel_in = 4'(wdata & SEL_MASK);
               ADDR_BANK_DATA: begin
                  bank_wr = 1'b1;
                  if (sel_ff <= SEL_LAST_PAT) begin
                     pat_in[sel_ff[2:0]] = wdata;
                  end else if (sel_ff == SEL_PRG0) begin
                     prg_in[0] = 6'(wdata & PRG_MASK);
                  end else if (sel_ff == SEL_PRG1) begin
                     prg_in[1] = 6'(wdata & PRG_MASK);
                  end
               end
               ADDR_MIRROR:     mir_in  = wdata[0];
               ADDR_RELOAD:     rld_in  = wdata;
               ADDR_RELOAD_ARM: rldp_in = 1'b1;
               ADDR_IRQ_OFF: begin
                  irqen_in = 1'b0;
                  irqp_in  = 1'b0;
               end
               ADDR_IRQ_ON:     irqen_in = 1'b1;
               default: ;
            endcase
         end else if (req_tdata[24]) begin
            cnt_in  = cnt_next;
            rldp_in = 1'b0;
            if (cnt_next == 8'd0 && irqen_ff) begin
               irqp_in = 1'b1;
            end
         end
      end
      if (csr_we) begin
         case (csr_index)
            CSR_PRG_COUNT: prg_count_in = csr_wdata;
            CSR_CHR_COUNT: chr_count_in = csr_wdata;
            CSR_VERTICAL:  mir_in       = ~csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= PRG_COUNT_RESET;
         chr_count_ff <= CHR_COUNT_RESET;
         sel_ff       <= '0;
         pat_ff       <= '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};
         prg_ff       <= '{6'd0, 6'd1};
         mir_ff       <= ~VERTICAL_RESET;
         irqen_ff     <= 1'b0;
         cnt_ff       <= '0;
         rld_ff       <= '0;
         rldp_ff      <= 1'b0;
         irqp_ff      <= 1'b0;
      end else begin
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
         sel_ff       <= sel_in;
         pat_ff       <= pat_in;
         prg_ff       <= prg_in;
         mir_ff       <= mir_in;
         irqen_ff     <= irqen_in;
         cnt_ff       <= cnt_in;
         rld_ff       <= rld_in;
         rldp_ff      <= rldp_in;
         irqp_ff      <= irqp_in;
      end
   end

   // control word for the current step
   assign uw = ucode(step_ff);

   always_comb begin
      case (uw.src)
         SRC_PRG:      operand = {2'b00, prg_ff[uw.reg_idx[0]]};
         SRC_FIXED:    operand = prg_count_ff + FIXED_OFFSET + {7'd0, uw.reg_idx[0]};
         SRC_PAT_EVEN: operand = pat_ff[uw.reg_idx] & PAT_EVEN_MSK;
         SRC_PAT_ODD:  operand = pat_ff[uw.reg_idx] | PAT_ODD_BIT;
         SRC_PAT:      operand = pat_ff[uw.reg_idx];
         default:      operand = '0;
      endcase
   end

   // a zero program bank count passes the register through
   assign mod_needed = (uw.modsel == MOD_CHR) ||
                       (uw.modsel == MOD_PRG && prg_count_ff != 8'd0);

   assign rem_req.start    = (state_ff == S_FETCH) && mod_needed;
   assign rem_req.dividend = operand;
   assign rem_req.divisor  = (uw.modsel == MOD_CHR) ? chr_count_ff : prg_count_ff;

   cbm_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   assign map_load = (state_ff == S_PUT) && out_free;
   assign map_last = uw.last || (uw.end_if_ram && chr_count_ff == 8'd0);
   assign rsp_load = (req_fire && !bank_wr) || map_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (bank_wr) begin
                     step_ff  <= '0;
                     state_ff <= S_FETCH;
                  end else begin
                     rsp_kind_ff  <= KIND_STATUS;
                     rsp_slot_ff  <= '0;
                     rsp_bank_ff  <= '0;
                     rsp_mir_ff   <= mir_in;
                     rsp_irq_ff   <= irqp_in;
                     rsp_last_ff  <= 1'b1;
                  end
               end
            end
            S_FETCH: begin
               res_ff   <= operand;
               state_ff <= mod_needed ? S_DIV : S_PUT;
            end
            S_DIV: begin
               if (rem_rsp.done) begin
                  res_ff   <= rem_rsp.remainder;
                  state_ff <= S_PUT;
               end
            end
            S_PUT: begin
               if (map_load) begin
                  rsp_kind_ff  <= uw.kind;
                  rsp_slot_ff  <= uw.slot;
                  rsp_bank_ff  <= res_ff;
                  rsp_mir_ff   <= mir_ff;
                  rsp_irq_ff   <= irqp_ff;
                  rsp_last_ff  <= map_last;
                  if (map_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     step_ff  <= step_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_irq_ff, rsp_mir_ff, rsp_bank_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer never runs past the end of the program
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> step_ff <= LAST_STEP)
      else $error("sequencer step out of range");

   // remainder unit only works while the sequencer waits for it
   a_rem_owner: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.busy |-> state_ff == S_DIV)
      else $error("remainder unit busy outside divide step");

   // pattern records only when pattern memory is banked
   a_pattern_rom: assert property (@(posedge clock) disable iff (reset)
      map_load && uw.kind == KIND_PATTERN |-> chr_count_ff != 8'd0)
      else $error("pattern record issued with pattern RAM");

   // interrupt is raised only by a scanline tick
   a_irq_source: assert property (@(posedge clock) disable iff (reset)
      $rose(irqp_ff) |-> $past(req_fire && req_tuser == FUNC_TICK))
      else $error("irq raised without a scanline tick");

endmodule

@@ src/cbm_rem.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on cbm_pkg for the request and response structs.
module cbm_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  cbm_pkg::rem_req_type req,
   output cbm_pkg::rem_rsp_type rsp
);
   import cbm_pkg::*;

   localparam int CNT_W = $clog2(REM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] dsr_ff, dsr_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[REM_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // partial remainder stays below twice the divisor
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[REM_W-1:0] : trial[REM_W-1:0];
         dvd_in = {dvd_ff[REM_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(REM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ test/tb_cartridge_bank_mapper_with_scanline_irq_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the bank mapper: directed table, then random beats in
// several gap/stall phases, all checked against an in-bench mapper model.
// Depends on cbm_pkg and cartridge_bank_mapper_with_scanline_irq_top.
module tb_cartridge_bank_mapper_with_scanline_irq_top;
   import cbm_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 16;
   localparam int END_CYCLES  = 150;
   localparam int MAX_PRINTED = 50;
   localparam int PHASE_BEATS = 72;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]  csr_idx;
      logic [7:0]  csr_val;
      logic        func;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        rend;
      logic        typed;     // status beat with hand-written expectation
      logic        t_mirror;
      logic        t_irq;
   } stim_row_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] slot;
      logic [7:0] bank;
      logic       mirror;
      logic       irq;
      logic       last;
   } slot_rec_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = FUNC_WRITE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [7:0]              csr_wdata = '0;

   // mapper model state
   logic [7:0] prg_cnt = PRG_COUNT_RESET;
   logic [7:0] chr_cnt = CHR_COUNT_RESET;
   logic       vert_cfg = VERTICAL_RESET;
   logic [3:0] sel_idx = '0;
   logic [7:0] pat_reg [6] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};
   logic [5:0] prg_reg [2] = '{6'd0, 6'd1};
   logic       mirror_bit = 1'b1;
   logic       irq_en = 1'b0;
   logic [7:0] scan_cnt = '0;
   logic [7:0] reload_val = '0;
   logic       reload_arm = 1'b0;
   logic       irq_flag = 1'b0;

   slot_rec_type owed_recs [$];
   stim_row_type dir_rows [$];
   logic [3:0] known_sel [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, SEL_LAST_PAT, SEL_PRG0, SEL_PRG1};

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_go = 1'b0;
   logic rx_hold = 1'b0;
   int quiet = 0;
   int n_err = 0, n_in = 0, n_out = 0, n_maps = 0, n_irq = 0, n_csr = 0;

   cartridge_bank_mapper_with_scanline_irq_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] prg_fold(input logic [7:0] v);
      return (prg_cnt == 8'd0) ? v : v % prg_cnt;
   endfunction

   function automatic logic [15:0] reg_addr(input logic [15:0] base);
      logic [15:0] r;
      r = 16'($urandom);
      return base | (r & 16'h1FFE);
   endfunction

   function automatic stim_row_type beat_row(input logic func, input logic [15:0] addr,
                                             input logic [7:0] data, input logic rend,
                                             input logic typed, input logic m,
                                             input logic i);
      return '{ROW_BEAT, 2'd0, 8'd0, func, addr, data, rend, typed, m, i};
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [7:0] val);
      return '{ROW_CSR, idx, val, FUNC_WRITE, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0};
   endfunction

   task automatic push_rec(input logic [1:0] kind, input logic [2:0] slot,
                           input logic [7:0] bank, input logic last);
      slot_rec_type r;
      r = '{kind, slot, bank, mirror_bit, irq_flag, last};
      owed_recs.push_back(r);
   endtask

   // Apply one accepted beat to the model and queue the records it produces.
   task automatic advance_mapper(input logic func, input logic [15:0] addr,
                                 input logic [7:0] data, input logic rend);
      logic bank_wr;
      logic [7:0] fixed_lo, fixed_hi;
      bank_wr = 1'b0;
      if (func == FUNC_WRITE) begin
         case (addr & ADDR_MASK)
            ADDR_SELECT: sel_idx = data[3:0];
            ADDR_BANK_DATA: begin
               if (sel_idx <= SEL_LAST_PAT) pat_reg[sel_idx[2:0]] = data;
               else if (sel_idx == SEL_PRG0) prg_reg[0] = data[5:0];
               else if (sel_idx == SEL_PRG1) prg_reg[1] = data[5:0];
               bank_wr = 1'b1;
            end
            ADDR_MIRROR: mirror_bit = data[0];
            ADDR_RELOAD: reload_val = data;
            ADDR_RELOAD_ARM: reload_arm = 1'b1;
            ADDR_IRQ_OFF: begin
               irq_en = 1'b0;
               irq_flag = 1'b0;
            end
            ADDR_IRQ_ON: irq_en = 1'b1;
            default: ;
         endcase
      end else if (rend) begin
         if (scan_cnt == 8'd0 || reload_arm) scan_cnt = reload_val;
         else scan_cnt = scan_cnt - 8'd1;
         if (scan_cnt == 8'd0 && irq_en) irq_flag = 1'b1;
         reload_arm = 1'b0;
      end
      if (bank_wr) begin
         fixed_lo = prg_cnt - 8'd2;
         fixed_hi = prg_cnt - 8'd1;
         push_rec(KIND_PROGRAM, 3'd0, prg_fold({2'b00, prg_reg[0]}), 1'b0);
         push_rec(KIND_PROGRAM, 3'd1, prg_fold({2'b00, prg_reg[1]}), 1'b0);
         push_rec(KIND_PROGRAM, 3'd2, fixed_lo, 1'b0);
         push_rec(KIND_PROGRAM, 3'd3, fixed_hi, chr_cnt == 8'd0);
         if (chr_cnt != 8'd0) begin
            push_rec(KIND_PATTERN, 3'd0, (pat_reg[0] & PAT_EVEN_MSK) % chr_cnt, 1'b0);
            push_rec(KIND_PATTERN, 3'd1, (pat_reg[0] | PAT_ODD_BIT) % chr_cnt, 1'b0);
            push_rec(KIND_PATTERN, 3'd2, (pat_reg[1] & PAT_EVEN_MSK) % chr_cnt, 1'b0);
            push_rec(KIND_PATTERN, 3'd3, (pat_reg[1] | PAT_ODD_BIT) % chr_cnt, 1'b0);
            for (int k = 0; k < 4; k++)
               push_rec(KIND_PATTERN, 3'(k + 4), pat_reg[k + 2] % chr_cnt, k == 3);
         end
         n_maps++;
      end else begin
         push_rec(KIND_STATUS, 3'd0, 8'd0, 1'b1);
      end
   endtask

   task automatic send_item(input logic func, input logic [15:0] addr,
                            input logic [7:0] data, input logic rend);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, rend, data, addr};
      do @(posedge clock); while (!req_tready);
      n_in++;
      advance_mapper(func, addr, data, rend);
   endtask

   // Stop offering beats and let every owed record come back.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (owed_recs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PRG_COUNT: prg_cnt = val;
         CSR_CHR_COUNT: chr_cnt = val;
         CSR_VERTICAL: begin
            vert_cfg = val[0];
            mirror_bit = ~val[0];
         end
         default: ;
      endcase
      n_csr++;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] prg, input logic [7:0] chr, input logic vert);
      wait_drain();
      csr_put(CSR_PRG_COUNT, prg);
      csr_put(CSR_CHR_COUNT, chr);
      csr_put(CSR_VERTICAL, {7'd0, vert});
   endtask

   // Mostly select/bank-data pairs, ticks and IRQ control with random payloads;
   // a little noise at random addresses.
   task automatic run_random(input int beats, input int idle_pct, input int stall_pct);
      int done, r;
      logic [7:0] d, hi;
      logic [15:0] a;
      logic [3:0] idx;
      logic rb;
      done = 0;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (done < beats) begin
         r  = $urandom_range(99);
         d  = 8'($urandom);
         hi = 8'($urandom);
         rb = 1'($urandom);
         if (r < 30) begin
            if ($urandom_range(3) != 0) idx = known_sel[$urandom_range(7)];
            else idx = 4'($urandom_range(15));
            send_item(FUNC_WRITE, reg_addr(ADDR_SELECT), {hi[7:4], idx}, rb);
            send_item(FUNC_WRITE, reg_addr(ADDR_BANK_DATA), d, hi[0]);
            done += 2;
         end else if (r < 35) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_BANK_DATA), d, rb);
            done++;
         end else if (r < 55) begin
            a = 16'($urandom);
            send_item(FUNC_TICK, a, d, 1'b1);
            done++;
         end else if (r < 60) begin
            a = 16'($urandom);
            send_item(FUNC_TICK, a, d, 1'b0);
            done++;
         end else if (r < 67) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_MIRROR), d, rb);
            done++;
         end else if (r < 74) begin
            if ($urandom_range(4) < 3) d = 8'($urandom_range(6));
            send_item(FUNC_WRITE, reg_addr(ADDR_RELOAD), d, rb);
            done++;
         end else if (r < 80) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_RELOAD_ARM), d, rb);
            done++;
         end else if (r < 86) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_IRQ_ON), d, rb);
            done++;
         end else if (r < 91) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_IRQ_OFF), d, rb);
            done++;
         end else if (r < 96) begin
            send_item(FUNC_WRITE, reg_addr(ADDR_SELECT), d, rb);
            done++;
         end else begin
            a = 16'($urandom);
            send_item(FUNC_WRITE, a, d, rb);
            done++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      n_err++;
      if (n_err <= MAX_PRINTED)
         $display("mismatch %s: got %0h expected %0h at response beat %0d",
                  what, got, want, n_out);
   endtask

   task automatic check_rsp();
      slot_rec_type got, want;
      got = '{rsp_tuser, rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[11], rsp_tdata[12],
              rsp_tlast};
      n_out++;
      if (got.irq) n_irq++;
      if (owed_recs.size() == 0) begin
         report_mismatch("beat with nothing owed", int'(got), 0);
         return;
      end
      want = owed_recs.pop_front();
      if (got.kind != want.kind) report_mismatch("record_kind", got.kind, want.kind);
      if (got.slot != want.slot) report_mismatch("slot_index", got.slot, want.slot);
      if (got.bank != want.bank) report_mismatch("bank_number", got.bank, want.bank);
      if (got.mirror != want.mirror) report_mismatch("mirror_horizontal", got.mirror, want.mirror);
      if (got.irq != want.irq) report_mismatch("irq_line", got.irq, want.irq);
      if (got.last != want.last) report_mismatch("last_record", got.last, want.last);
   endtask

   // response side: check, then pick next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_rsp();
         rsp_tready <= !(rx_hold ||
                         (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct));
      end
   end

   // long response hold-off, so the block backs up into its input
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go <= 1'b0;
         rx_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rx_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles, %0d records owed",
                  quiet, owed_recs.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      // reset defaults, masking, unused selects, zero program count, IRQ path
      dir_rows.push_back(beat_row(FUNC_TICK, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(csr_row(CSR_PRG_COUNT, 8'd0));
      dir_rows.push_back(csr_row(CSR_CHR_COUNT, 8'd255));
      dir_rows.push_back(csr_row(CSR_VERTICAL, 8'd1));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h7FFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8000, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'hAA, 1'b1, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h9FFE, 8'h08, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8000, 8'h09, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8000, 8'h05, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hA000, 8'hFE, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hBFFE, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hC000, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hE001, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hC001, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      // armed reload of zero with IRQ enabled fires on the first tick
      dir_rows.push_back(beat_row(FUNC_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(beat_row(FUNC_TICK, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'hE000, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(csr_row(CSR_PRG_COUNT, 8'd255));
      dir_rows.push_back(csr_row(CSR_CHR_COUNT, 8'd1));
      dir_rows.push_back(beat_row(FUNC_WRITE, 16'h8001, 8'h7E, 1'b0, 1'b0, 1'b0, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         if (dir_rows[k].kind == ROW_CSR) begin
            wait_drain();
            csr_put(dir_rows[k].csr_idx, dir_rows[k].csr_val);
         end else begin
            send_item(dir_rows[k].func, dir_rows[k].addr, dir_rows[k].data, dir_rows[k].rend);
            if (dir_rows[k].typed) begin
               void'(owed_recs.pop_back());
               owed_recs.push_back('{KIND_STATUS, 3'd0, 8'd0, dir_rows[k].t_mirror,
                                     dir_rows[k].t_irq, 1'b1});
            end
         end
      end

      set_config(8'd254, 8'd255, 1'b0);
      hold_go = 1'b1;
      run_random(PHASE_BEATS, 0, 0);
      set_config(8'd2, 8'd0, 1'b1);
      run_random(PHASE_BEATS, 80, 0);
      set_config(8'($urandom_range(3, 253)), 8'($urandom_range(1, 254)),
                 1'($urandom_range(1)));
      run_random(PHASE_BEATS, 0, 80);
      set_config(8'($urandom_range(2, 16)), 8'($urandom_range(1, 16)),
                 1'($urandom_range(1)));
      run_random(PHASE_BEATS, 38, 38);

      wait_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (owed_recs.size() != 0) report_mismatch("records never returned", owed_recs.size(), 0);

      $display("run: %0d request beats, %0d response beats, %0d slot maps, %0d with irq set",
               n_in, n_out, n_maps, n_irq);
      $display("run: %0d register writes, gap/stall phases, %0d-cycle response hold-off",
               n_csr, HOLD_CYCLES);
      if (n_err == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", n_err);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ cartridge_bank_mapper_with_scanline_irq_top.f @@
src/cbm_pkg.sv
src/cbm_rem.sv
src/cartridge_bank_mapper_with_scanline_irq_top.sv
test/tb_cartridge_bank_mapper_with_scanline_irq_top.sv
